// ===== sv/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = 5;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ACT_W = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOCATE = 2'd2
	} action_t;

	typedef struct packed {
		logic load;
		logic ptr_ld;
		logic rd;
		logic fwd;
		logic shift;
		logic loc_chk;
		logic put;
		logic rm_cap;
		logic cnt_inc;
		logic cnt_dec;
		logic res_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic op_ok;
		logic append;
		logic del_last;
		logic cnt_zero;
		logic ins_end;
		logic scan_end;
		logic out_busy;
	} dp_stat_t;

endpackage

// ===== sv/pal_req_if.sv =====
`timescale 1ns / 1ps

interface pal_req_if;
	import pal_pkg::*;

	logic valid;
	logic ready;
	logic [ACT_W-1:0] action;
	logic [POS_W-1:0] position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, action, position, value, input ready);
	modport sink (input valid, action, position, value, output ready);

endinterface

// ===== sv/pal_rsp_if.sv =====
`timescale 1ns / 1ps

interface pal_rsp_if;
	import pal_pkg::*;

	logic valid;
	logic ready;
	logic ok;
	logic signed [VAL_W-1:0] removed_value;
	logic [POS_W-1:0] found_position;
	logic [CNT_W-1:0] count;
	logic is_empty;

	modport source (output valid, ok, removed_value, found_position, count, is_empty,
		input ready);
	modport sink (input valid, ok, removed_value, found_position, count, is_empty,
		output ready);

endinterface

// ===== sv/pal_ctrl.sv =====
`timescale 1ns / 1ps

module pal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pal_pkg::dp_stat_t stat,
	output pal_pkg::dp_cmd_t  cmd
);
	import pal_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b000000000001,
		ST_DISPATCH  = 12'b000000000010,
		ST_INS_SHIFT = 12'b000000000100,
		ST_INS_DRAIN = 12'b000000001000,
		ST_INS_PUT   = 12'b000000010000,
		ST_DEL_RD    = 12'b000000100000,
		ST_DEL_CAP   = 12'b000001000000,
		ST_DEL_SHIFT = 12'b000010000000,
		ST_DEL_DRAIN = 12'b000100000000,
		ST_LOC_SCAN  = 12'b001000000000,
		ST_LOC_LAST  = 12'b010000000000,
		ST_FINISH    = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.ptr_ld = 1'b1;
				case (stat.act)
					ACT_INSERT: begin
						if (!stat.op_ok) begin
							state_d = ST_FINISH;
						end else if (stat.append) begin
							state_d = ST_INS_PUT;
						end else begin
							state_d = ST_INS_SHIFT;
						end
					end
					ACT_DELETE: begin
						state_d = stat.op_ok ? ST_DEL_RD : ST_FINISH;
					end
					ACT_LOCATE: begin
						state_d = stat.cnt_zero ? ST_FINISH : ST_LOC_SCAN;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_INS_SHIFT: begin
				cmd.rd = 1'b1;
				cmd.shift = 1'b1;
				if (stat.ins_end) begin
					state_d = ST_INS_DRAIN;
				end
			end
			ST_INS_DRAIN: begin
				state_d = ST_INS_PUT;
			end
			ST_INS_PUT: begin
				cmd.put = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d = ST_FINISH;
			end
			ST_DEL_RD: begin
				cmd.rd = 1'b1;
				cmd.fwd = 1'b1;
				state_d = ST_DEL_CAP;
			end
			ST_DEL_CAP: begin
				cmd.rm_cap = 1'b1;
				if (stat.del_last) begin
					cmd.cnt_dec = 1'b1;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DEL_SHIFT;
				end
			end
			ST_DEL_SHIFT: begin
				cmd.rd = 1'b1;
				cmd.fwd = 1'b1;
				cmd.shift = 1'b1;
				if (stat.scan_end) begin
					state_d = ST_DEL_DRAIN;
				end
			end
			ST_DEL_DRAIN: begin
				cmd.cnt_dec = 1'b1;
				state_d = ST_FINISH;
			end
			ST_LOC_SCAN: begin
				cmd.rd = 1'b1;
				cmd.fwd = 1'b1;
				cmd.loc_chk = 1'b1;
				if (stat.scan_end) begin
					state_d = ST_LOC_LAST;
				end
			end
			ST_LOC_LAST: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.res_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/pal_datapath.sv =====
`timescale 1ns / 1ps

module pal_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pal_pkg::ACT_W-1:0]         action,
	input  logic [pal_pkg::POS_W-1:0]         position,
	input  logic signed [pal_pkg::VAL_W-1:0]  value,
	input  pal_pkg::dp_cmd_t                  cmd,
	output pal_pkg::dp_stat_t                 stat,
	pal_rsp_if.source                         rsp
);
	import pal_pkg::*;

	logic [VAL_W-1:0] mem_q [CAPACITY];
	logic [VAL_W-1:0] rd_data_q;

	logic [ACT_W-1:0] act_q;
	logic [CNT_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ok_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] dst_q;
	logic [ADDR_W-1:0] tag_q;
	logic             pend_q;
	logic             chk_q;
	logic             hit_q;
	logic [CNT_W-1:0] found_q;
	logic [VAL_W-1:0] removed_q;

	logic             rsp_valid_q;
	logic             rsp_ok_q;
	logic [VAL_W-1:0] rsp_removed_q;
	logic [CNT_W-1:0] rsp_found_q;
	logic [CNT_W-1:0] rsp_count_q;
	logic             rsp_empty_q;

	logic [CNT_W:0]   in_pos_x;
	logic [CNT_W:0]   cnt_x;
	logic             in_ins_ok;
	logic             in_del_ok;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] cnt_m1;
	logic [ADDR_W-1:0] ptr_init;
	logic             cmp_hit;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	assign in_pos_x = (CNT_W+1)'(position);
	assign cnt_x = (CNT_W+1)'(cnt_q);
	assign in_ins_ok = (position != '0) && (in_pos_x <= cnt_x + (CNT_W+1)'(1))
		&& (cnt_q < CNT_W'(CAPACITY));
	assign in_del_ok = (position != '0) && (in_pos_x <= cnt_x);

	assign pos_m1 = pos_q - CNT_W'(1);
	assign cnt_m1 = cnt_q - CNT_W'(1);

	always_comb begin
		case (act_q)
			ACT_INSERT: ptr_init = cnt_m1[ADDR_W-1:0];
			ACT_DELETE: ptr_init = pos_m1[ADDR_W-1:0];
			default:    ptr_init = '0;
		endcase
	end

	assign cmp_hit = chk_q && (rd_data_q == val_q);

	assign wr_en = pend_q || cmd.put;
	assign wr_addr = pend_q ? dst_q : pos_m1[ADDR_W-1:0];
	assign wr_data = pend_q ? rd_data_q : val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_q <= 1'b0;
			chk_q <= 1'b0;
			hit_q <= 1'b0;
			ok_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.shift;
			chk_q <= cmd.loc_chk;
			if (cmd.load) begin
				ok_q <= ((action == ACT_INSERT) && in_ins_ok)
					|| ((action == ACT_DELETE) && in_del_ok);
				hit_q <= 1'b0;
			end else if (cmp_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.res_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			pos_q <= CNT_W'(position);
			val_q <= value;
			found_q <= '0;
			removed_q <= '0;
		end else begin
			if (cmp_hit && !hit_q) begin
				found_q <= CNT_W'(tag_q) + CNT_W'(1);
			end
			if (cmd.rm_cap) begin
				removed_q <= rd_data_q;
			end
		end
		if (cmd.ptr_ld) begin
			ptr_q <= ptr_init;
		end else if (cmd.rd) begin
			ptr_q <= cmd.fwd ? ptr_q + ADDR_W'(1) : ptr_q - ADDR_W'(1);
		end
		if (cmd.rd) begin
			tag_q <= ptr_q;
			dst_q <= cmd.fwd ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
		end
		if (cmd.res_ld) begin
			rsp_ok_q <= ok_q || hit_q;
			rsp_removed_q <= removed_q;
			rsp_found_q <= found_q;
			rsp_count_q <= cnt_q;
			rsp_empty_q <= (cnt_q == '0);
		end
	end

	assign stat.act = act_q;
	assign stat.op_ok = ok_q;
	assign stat.append = (pos_q == cnt_q + CNT_W'(1));
	assign stat.del_last = (pos_q == cnt_q);
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.ins_end = (CNT_W'(ptr_q) == pos_m1);
	assign stat.scan_end = (CNT_W'(ptr_q) == cnt_m1);
	assign stat.out_busy = rsp_valid_q && !rsp.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.ok = rsp_ok_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.found_position = POS_W'(rsp_found_q);
	assign rsp.count = rsp_count_q;
	assign rsp.is_empty = rsp_empty_q;

endmodule

// ===== sv/positional_array_list_unit.sv =====
`timescale 1ns / 1ps

// Packed list of up to CAPACITY signed 32-bit entries that serves insert, delete and
// locate requests one at a time. A request is taken on the req channel only while no
// other request is in progress, and its single result appears on the rsp channel.
// A refused request, an undefined action and a locate on an empty list go straight to
// their result; an insert that appends at the end writes its entry without a shift, a
// delete that takes the last entry captures it without a shift, and every other request
// shifts or scans the list. The entry memory has one read port and one write port, so
// the walk moves or compares one entry per cycle. A result that is still stalled on the
// rsp channel holds the next one back, and a new request can be taken in the same cycle
// as the previous result becomes valid.
// The entry memory needs no clearing after reset, since only written entries are read.
module positional_array_list_unit (
	input  logic        clk,
	input  logic        arst_n,
	pal_req_if.sink     req,
	pal_rsp_if.source   rsp
);
	import pal_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pal_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.action   (req.action),
		.position (req.position),
		.value    (req.value),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

// ===== sv/pal_checker.sv =====
`timescale 1ns / 1ps

module pal_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic                            rsp_ok,
	input logic [pal_pkg::VAL_W-1:0]       rsp_removed_value,
	input logic [pal_pkg::POS_W-1:0]       rsp_found_position,
	input logic [pal_pkg::CNT_W-1:0]       rsp_count,
	input logic                            rsp_is_empty
);
	import pal_pkg::*;

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
		else $error("is_empty disagrees with count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_count <= CNT_W'(CAPACITY)))
		else $error("count above capacity");

	a_found_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && ((rsp_found_position != '0) || (rsp_removed_value != '0)))
		|-> (rsp_ok && ((rsp_found_position == '0) || (rsp_removed_value == '0))))
		else $error("found or removed value without a successful request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count)
		&& $stable(rsp_ok)))
		else $error("stalled result changed");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_ok             (rsp.ok),
	.rsp_removed_value  (rsp.removed_value),
	.rsp_found_position (rsp.found_position),
	.rsp_count          (rsp.count),
	.rsp_is_empty       (rsp.is_empty)
);
